// File: hdl/revi_pkg.sv
package revi_pkg;

    localparam int SAMPLE_W = 16;
    localparam int NUM_W    = 32;
    localparam int DEN_W    = 19;
    localparam int REM_W    = 35;
    localparam int QUO_W    = 17;
    localparam int LANES    = 4;
    localparam int CELLS    = QUO_W;
    localparam int LATENCY  = CELLS + 2;

    localparam int LANE_NDRE = 0;
    localparam int LANE_REPI = 1;
    localparam int LANE_PSRI = 2;
    localparam int LANE_CIRE = 3;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             zero;
    } lane_t;

    typedef lane_t [LANES-1:0] row_t;

    function automatic lane_t prep_lane(logic signed [NUM_W-1:0] n,
                                        logic signed [NUM_W-1:0] d,
                                        logic                    skip);
        lane_t            l;
        logic [NUM_W-1:0] a;
        logic [NUM_W-1:0] b;
        a = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
        b = d[NUM_W-1] ? NUM_W'(-d) : NUM_W'(d);
        l.rem  = REM_W'({a, 1'b0}) + REM_W'(b);
        l.den  = DEN_W'({b, 1'b0});
        l.quo  = '0;
        l.neg  = n[NUM_W-1] ^ d[NUM_W-1];
        l.zero = skip || (d == '0);
        return l;
    endfunction

endpackage

// File: hdl/revi_prep.sv
module revi_prep
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [revi_pkg::SAMPLE_W-1:0] bg,
    input  logic signed [revi_pkg::SAMPLE_W-1:0] b2,
    input  logic signed [revi_pkg::SAMPLE_W-1:0] b4,
    input  logic signed [revi_pkg::SAMPLE_W-1:0] b5,
    input  logic signed [revi_pkg::SAMPLE_W-1:0] b6,
    input  logic signed [revi_pkg::SAMPLE_W-1:0] b7,
    input  logic signed [revi_pkg::SAMPLE_W-1:0] b8,
    output logic                                 out_valid,
    output revi_pkg::row_t                       out_row
);

    logic signed [revi_pkg::NUM_W-1:0] e2, e4, e5, e6, e7, e8;
    logic signed [revi_pkg::NUM_W-1:0] repi_d;
    logic                              h2, h4, h5, h6, h7, h8;
    logic                              valid_reg;
    revi_pkg::row_t                    row_reg, row_next;

    always_comb
    begin
        e2 = revi_pkg::NUM_W'(b2);
        e4 = revi_pkg::NUM_W'(b4);
        e5 = revi_pkg::NUM_W'(b5);
        e6 = revi_pkg::NUM_W'(b6);
        e7 = revi_pkg::NUM_W'(b7);
        e8 = revi_pkg::NUM_W'(b8);
        h2 = (b2 == bg);
        h4 = (b4 == bg);
        h5 = (b5 == bg);
        h6 = (b6 == bg);
        h7 = (b7 == bg);
        h8 = (b8 == bg);
        repi_d = (e6 - e5) <<< 1;
        row_next[revi_pkg::LANE_NDRE] = revi_pkg::prep_lane(10000 * (e8 - e6), e8 + e6,
                                                            h6 || h8);
        row_next[revi_pkg::LANE_REPI] = revi_pkg::prep_lane(
            705 * repi_d + 35 * (e7 + e4 - (e5 <<< 1)), repi_d, h4 || h5 || h6 || h7);
        row_next[revi_pkg::LANE_PSRI] = revi_pkg::prep_lane(10000 * (e4 - e2), e5,
                                                            h2 || h4 || h5);
        row_next[revi_pkg::LANE_CIRE] = revi_pkg::prep_lane(10000 * e5, e8, h5 || h8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign out_valid = valid_reg;
    assign out_row   = row_reg;

endmodule

// File: hdl/revi_cell.sv
module revi_cell
#(
    parameter int SHIFT = 0
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  revi_pkg::row_t in_row,
    output logic           out_valid,
    output revi_pkg::row_t out_row
);

    logic           valid_reg;
    revi_pkg::row_t row_reg, row_next;
    logic [revi_pkg::REM_W-1:0] trial [revi_pkg::LANES];

    always_comb
    begin
        row_next = in_row;
        for (int i = 0; i < revi_pkg::LANES; i++)
        begin
            trial[i] = revi_pkg::REM_W'(in_row[i].den) << SHIFT;
            if (in_row[i].rem >= trial[i])
            begin
                row_next[i].rem        = in_row[i].rem - trial[i];
                row_next[i].quo[SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign out_valid = valid_reg;
    assign out_row   = row_reg;

endmodule

// File: hdl/revi_post.sv
module revi_post
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  revi_pkg::row_t                       in_row,
    output logic                                 out_valid,
    output logic [revi_pkg::LANES-1:0][revi_pkg::SAMPLE_W-1:0] out_value
);

    logic valid_reg;
    logic [revi_pkg::LANES-1:0][revi_pkg::SAMPLE_W-1:0] value_reg, value_next;

    always_comb
    begin
        for (int i = 0; i < revi_pkg::LANES; i++)
        begin
            priority if (in_row[i].zero)
                value_next[i] = '0;
            else if (in_row[i].neg)
                value_next[i] = (in_row[i].quo > revi_pkg::QUO_W'(32768))
                              ? 16'h8000
                              : revi_pkg::SAMPLE_W'(-in_row[i].quo);
            else
                value_next[i] = (in_row[i].quo > revi_pkg::QUO_W'(32767))
                              ? 16'h7fff
                              : revi_pkg::SAMPLE_W'(in_row[i].quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;

endmodule

// File: hdl/red_edge_vegetation_indices_top.sv
// red-edge vegetation indices: ndre, repi, psri and cire of one pixel
// input channel: start with the six band samples; busy is always low, so a
// beat is taken on every cycle that start is high, one pixel per clock
// output channel: done is high for one cycle with the four indices; the
// receiver cannot stall and must take every beat as it comes
// latency: 19 cycles from the start edge to the done cycle, set by one
// preparation stage, a row of 17 divide cells (one quotient bit each) and
// one rounding and saturation stage
// throughput: one pixel per cycle, fully pipelined
// background_we / background_data write the no-data sample value, taken on
// any edge with background_we high; write it while no beat is in flight
// reset: clears the pipeline valid flags and sets the no-data value to 0;
// beats in flight at reset are dropped
module red_edge_vegetation_indices_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        background_we,
    input  logic [15:0] background_data,
    input  logic [15:0] band_blue,
    input  logic [15:0] band_red,
    input  logic [15:0] band_edge_one,
    input  logic [15:0] band_edge_two,
    input  logic [15:0] band_edge_three,
    input  logic [15:0] band_near_ir,
    output logic        done,
    output logic [15:0] ndre_value,
    output logic [15:0] repi_value,
    output logic [15:0] psri_value,
    output logic [15:0] cire_value
);

    logic [15:0]    background_reg;
    logic           valid [revi_pkg::CELLS+1];
    revi_pkg::row_t row   [revi_pkg::CELLS+1];
    logic [revi_pkg::LANES-1:0][revi_pkg::SAMPLE_W-1:0] value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            background_reg <= '0;
        end
        else if (background_we)
        begin
            background_reg <= background_data;
        end
    end

    assign busy = 1'b0;

    revi_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .bg        (background_reg),
        .b2        (band_blue),
        .b4        (band_red),
        .b5        (band_edge_one),
        .b6        (band_edge_two),
        .b7        (band_edge_three),
        .b8        (band_near_ir),
        .out_valid (valid[0]),
        .out_row   (row[0])
    );

    for (genvar k = 0; k < revi_pkg::CELLS; k++)
    begin : g_cell
        revi_cell #(.SHIFT(revi_pkg::CELLS - 1 - k)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[k]),
            .in_row    (row[k]),
            .out_valid (valid[k+1]),
            .out_row   (row[k+1])
        );
    end

    revi_post u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid[revi_pkg::CELLS]),
        .in_row    (row[revi_pkg::CELLS]),
        .out_valid (done),
        .out_value (value)
    );

    assign ndre_value = value[revi_pkg::LANE_NDRE];
    assign repi_value = value[revi_pkg::LANE_REPI];
    assign psri_value = value[revi_pkg::LANE_PSRI];
    assign cire_value = value[revi_pkg::LANE_CIRE];

`ifndef SYNTH
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(revi_pkg::LATENCY) done)
        else $error("beat lost in pipeline");
    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, revi_pkg::LATENCY))
        else $error("beat invented in pipeline");
    a_bg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !background_we && (band_edge_one == background_reg)
        |-> ##(revi_pkg::LATENCY) (repi_value == '0 && psri_value == '0 && cire_value == '0))
        else $error("background pixel gave nonzero index");
`endif

endmodule
